/* rtl/core/ps2_set1_scancode_decoder_fifo_defines.svh */
// Assertion macros for the PS/2 set-1 decoder block.
// Standalone header; no dependencies.
`ifndef PS2_SET1_SCANCODE_DECODER_FIFO_DEFINES_SVH
`define PS2_SET1_SCANCODE_DECODER_FIFO_DEFINES_SVH
`ifndef SYNTH
`define PS2_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PS2_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PS2_ASSERT(lbl, clk, rst, prop, msg)
`define PS2_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/ps2kbd_pkg.sv */
// Shared types, scancode constants and ASCII tables for the PS/2 set-1 decoder.
// No dependencies.
package ps2kbd_pkg;

  localparam int CODE_W = 9;  // widest code is a special, 0x100 + n

  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [7:0] SC_C       = 8'h2E;
  localparam logic [7:0] SC_TAB     = 8'h0F;
  localparam logic [7:0] SC_UP      = 8'h48;
  localparam logic [7:0] SC_DOWN    = 8'h50;
  localparam logic [7:0] SC_LEFT    = 8'h4B;
  localparam logic [7:0] SC_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_HOME    = 8'h47;
  localparam logic [7:0] SC_END     = 8'h4F;
  localparam logic [7:0] SC_PGUP    = 8'h49;
  localparam logic [7:0] SC_PGDN    = 8'h51;
  localparam logic [5:0] SC_MAP_LEN = 6'd58;

  localparam logic [CODE_W-1:0] CODE_UP    = 9'h100;
  localparam logic [CODE_W-1:0] CODE_DOWN  = 9'h101;
  localparam logic [CODE_W-1:0] CODE_LEFT  = 9'h102;
  localparam logic [CODE_W-1:0] CODE_RIGHT = 9'h103;
  localparam logic [CODE_W-1:0] CODE_HOME  = 9'h104;
  localparam logic [CODE_W-1:0] CODE_END   = 9'h105;
  localparam logic [CODE_W-1:0] CODE_PGUP  = 9'h106;
  localparam logic [CODE_W-1:0] CODE_PGDN  = 9'h107;
  localparam logic [CODE_W-1:0] CODE_TAB   = 9'h108;
  localparam logic [CODE_W-1:0] CODE_CTRLC = 9'h109;

  localparam logic [15:0] KEY_NONE = 16'hFFFF;

  typedef logic [CODE_W-1:0] code_t;

  // decoder -> queue
  typedef struct packed {
    logic  hit;
    code_t code;
  } dec_t;

  function automatic logic [7:0] plain_ascii(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd1:  c = 8'h1B;  6'd2:  c = 8'h31;  6'd3:  c = 8'h32;  6'd4:  c = 8'h33;
      6'd5:  c = 8'h34;  6'd6:  c = 8'h35;  6'd7:  c = 8'h36;  6'd8:  c = 8'h37;
      6'd9:  c = 8'h38;  6'd10: c = 8'h39;  6'd11: c = 8'h30;  6'd12: c = 8'h2D;
      6'd13: c = 8'h3D;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h71;
      6'd17: c = 8'h77;  6'd18: c = 8'h65;  6'd19: c = 8'h72;  6'd20: c = 8'h74;
      6'd21: c = 8'h79;  6'd22: c = 8'h75;  6'd23: c = 8'h69;  6'd24: c = 8'h6F;
      6'd25: c = 8'h70;  6'd26: c = 8'h5B;  6'd27: c = 8'h5D;  6'd28: c = 8'h0A;
      6'd30: c = 8'h61;  6'd31: c = 8'h73;  6'd32: c = 8'h64;  6'd33: c = 8'h66;
      6'd34: c = 8'h67;  6'd35: c = 8'h68;  6'd36: c = 8'h6A;  6'd37: c = 8'h6B;
      6'd38: c = 8'h6C;  6'd39: c = 8'h3B;  6'd40: c = 8'h27;  6'd41: c = 8'h60;
      6'd43: c = 8'h5C;  6'd44: c = 8'h7A;  6'd45: c = 8'h78;  6'd46: c = 8'h63;
      6'd47: c = 8'h76;  6'd48: c = 8'h62;  6'd49: c = 8'h6E;  6'd50: c = 8'h6D;
      6'd51: c = 8'h2C;  6'd52: c = 8'h2E;  6'd53: c = 8'h2F;  6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upper_ascii(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd1:  c = 8'h1B;  6'd2:  c = 8'h21;  6'd3:  c = 8'h40;  6'd4:  c = 8'h23;
      6'd5:  c = 8'h24;  6'd6:  c = 8'h25;  6'd7:  c = 8'h5E;  6'd8:  c = 8'h26;
      6'd9:  c = 8'h2A;  6'd10: c = 8'h28;  6'd11: c = 8'h29;  6'd12: c = 8'h5F;
      6'd13: c = 8'h2B;  6'd14: c = 8'h08;  6'd15: c = 8'h09;  6'd16: c = 8'h51;
      6'd17: c = 8'h57;  6'd18: c = 8'h45;  6'd19: c = 8'h52;  6'd20: c = 8'h54;
      6'd21: c = 8'h59;  6'd22: c = 8'h55;  6'd23: c = 8'h49;  6'd24: c = 8'h4F;
      6'd25: c = 8'h50;  6'd26: c = 8'h7B;  6'd27: c = 8'h7D;  6'd28: c = 8'h0A;
      6'd30: c = 8'h41;  6'd31: c = 8'h53;  6'd32: c = 8'h44;  6'd33: c = 8'h46;
      6'd34: c = 8'h47;  6'd35: c = 8'h48;  6'd36: c = 8'h4A;  6'd37: c = 8'h4B;
      6'd38: c = 8'h4C;  6'd39: c = 8'h3A;  6'd40: c = 8'h22;  6'd41: c = 8'h7E;
      6'd43: c = 8'h7C;  6'd44: c = 8'h5A;  6'd45: c = 8'h58;  6'd46: c = 8'h43;
      6'd47: c = 8'h56;  6'd48: c = 8'h42;  6'd49: c = 8'h4E;  6'd50: c = 8'h4D;
      6'd51: c = 8'h3C;  6'd52: c = 8'h3E;  6'd53: c = 8'h3F;  6'd55: c = 8'h2A;
      6'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/ps2_set1_scancode_decoder_fifo.sv */
// PS/2 set-1 scancode decoder with key-code queue: top level.
// Depends on ps2kbd_pkg, ps2kbd_decode and ps2kbd_fifo.
//
// Each input item is either a raw set-1 scancode byte (action 0) or a pop
// request (action 1), and each gives exactly one result item. Scancodes
// track shift/ctrl/alt and the E0 prefix and may queue a code: US ASCII, or
// 0x100+n for up, down, left, right, home, end, page up, page down, tab and
// ctrl+C. The queue holds QUEUE_DEPTH-1 codes; a code produced while it is
// full is lost and flagged by dropped. A pop returns the oldest code, or
// 0xFFFF with queue_empty set. Throughput is one item per clock when the
// output is not stalled. An input register is followed by the result
// register, the result stage being where the queue memory's registered read
// lands. A stalled output holds one result while one more item waits in the
// input register. Reset clears flags and pointers at once; there is no
// clearing pass, and queue entries are only returned once written.
module ps2_set1_scancode_decoder_fifo #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  scan_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] key_code,
  output logic        queue_empty,
  output logic        queued,
  output logic        dropped
);
  import ps2kbd_pkg::*;

  // input stage
  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_byte;

  // result stage
  logic       res_pop;

  logic  adv;     // result register free or being emptied
  logic  step;    // the item in the input stage moves on this edge
  logic  push, pop, full, empty;
  dec_t  dec;
  code_t rd_data;

  assign adv      = !out_valid || out_ready;
  assign step     = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_byte   <= scan_byte;
    end
  end

  ps2kbd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (step && !s1_action),
    .scan_byte (s1_byte),
    .dec       (dec)
  );

  // a produced code goes in unless the queue is full
  assign push = step && !s1_action && dec.hit && !full;
  assign pop  = step && s1_action && !empty;

  ps2kbd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .push    (push),
    .pop     (pop),
    .wr_data (dec.code),
    .rd_data (rd_data),
    .full    (full),
    .empty   (empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_pop     <= s1_action;
      queue_empty <= s1_action && empty;
      queued      <= !s1_action && dec.hit && !full;
      dropped     <= !s1_action && dec.hit && full;
    end
  end

  // rd_data already holds the entry read on the step edge
  always_comb begin
    if (!res_pop) begin
      key_code = '0;
    end else if (queue_empty) begin
      key_code = KEY_NONE;
    end else begin
      key_code = {{(16 - CODE_W){1'b0}}, rd_data};
    end
  end

endmodule

/* rtl/core/ps2kbd_decode.sv */
// Set-1 scancode decoder: modifier and E0 prefix flags, code lookup.
// Depends on ps2kbd_pkg.
module ps2kbd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,         // take scan_byte this cycle
  input  logic [7:0]        scan_byte,
  output ps2kbd_pkg::dec_t  dec
);
  import ps2kbd_pkg::*;

  logic shift_held, ctrl_held, alt_held, prefix_seen;
  logic shift_held_next, ctrl_held_next, alt_held_next, prefix_seen_next;
  logic [6:0] k;
  logic [7:0] asc;

  assign k   = scan_byte[6:0];
  assign asc = shift_held ? upper_ascii(scan_byte[5:0]) : plain_ascii(scan_byte[5:0]);

  always_comb begin
    shift_held_next  = shift_held;
    ctrl_held_next   = ctrl_held;
    alt_held_next    = alt_held;
    prefix_seen_next = prefix_seen;
    dec.hit  = 1'b0;
    dec.code = '0;
    if (scan_byte == SC_PREFIX) begin
      prefix_seen_next = 1'b1;
    end else if (scan_byte[7]) begin
      // break: an extended one only drops the prefix
      if (prefix_seen) begin
        prefix_seen_next = 1'b0;
      end else begin
        if (k == SC_LSHIFT || k == SC_RSHIFT) shift_held_next = 1'b0;
        if (k == SC_CTRL) ctrl_held_next = 1'b0;
        if (k == SC_ALT)  alt_held_next  = 1'b0;
      end
    end else if (prefix_seen) begin
      prefix_seen_next = 1'b0;
      dec.hit = 1'b1;
      case (scan_byte)
        SC_UP:    dec.code = CODE_UP;
        SC_DOWN:  dec.code = CODE_DOWN;
        SC_LEFT:  dec.code = CODE_LEFT;
        SC_RIGHT: dec.code = CODE_RIGHT;
        SC_HOME:  dec.code = CODE_HOME;
        SC_END:   dec.code = CODE_END;
        SC_PGUP:  dec.code = CODE_PGUP;
        SC_PGDN:  dec.code = CODE_PGDN;
        default:  dec.hit  = 1'b0;
      endcase
    end else if (k == SC_LSHIFT || k == SC_RSHIFT) begin
      shift_held_next = 1'b1;
    end else if (k == SC_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (k == SC_ALT) begin
      alt_held_next = 1'b1;
    end else if (ctrl_held && scan_byte == SC_C) begin
      dec.hit  = 1'b1;
      dec.code = CODE_CTRLC;
    end else if (scan_byte == SC_TAB) begin
      dec.hit  = 1'b1;
      dec.code = CODE_TAB;
    end else if (scan_byte[7:6] == 2'b00 && scan_byte[5:0] < SC_MAP_LEN) begin
      dec.hit  = (asc != 8'h00);
      dec.code = {1'b0, asc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      alt_held    <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (en) begin
      shift_held  <= shift_held_next;
      ctrl_held   <= ctrl_held_next;
      alt_held    <= alt_held_next;
      prefix_seen <= prefix_seen_next;
    end
  end

endmodule

/* rtl/core/ps2kbd_fifo.sv */
// Key-code ring queue, one slot kept free, registered read port.
// Depends on ps2kbd_pkg and the block's assertion macro header.
`include "ps2_set1_scancode_decoder_fifo_defines.svh"
module ps2kbd_fifo #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,     // an item moves to the result stage
  input  logic              push,
  input  logic              pop,
  input  ps2kbd_pkg::code_t wr_data,
  output ps2kbd_pkg::code_t rd_data,
  output logic              full,
  output logic              empty
);
  import ps2kbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  code_t          mem [DEPTH];
  logic [PW-1:0]  write_ptr, read_ptr;
  logic [PW-1:0]  write_ptr_inc, read_ptr_inc;

  assign write_ptr_inc = (write_ptr == LAST) ? '0 : write_ptr + 1'b1;
  assign read_ptr_inc  = (read_ptr  == LAST) ? '0 : read_ptr  + 1'b1;
  assign empty = (read_ptr == write_ptr);
  assign full  = (write_ptr_inc == read_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      if (push) write_ptr <= write_ptr_inc;
      if (pop)  read_ptr  <= read_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[write_ptr] <= wr_data;
    if (step) rd_data <= mem[read_ptr];
  end

  `PS2_ASSERT_NEXT(a_push_fills, clk, rst, push, !empty, "queue empty after a push")
  `PS2_ASSERT_NEXT(a_pop_frees, clk, rst, pop, !full, "queue full after a pop")
  `PS2_ASSERT(a_full_not_empty, clk, rst, !(full && empty), "queue both full and empty")
  `PS2_ASSERT(a_ops_need_step, clk, rst, !((push || pop) && !step), "queue op without a step")

endmodule
